// ===== design/sparse_polynomial_term_table_macros.svh =====
// ----------------------------------------------------------------------------
// Sparse polynomial term table: assertion macros
// Shared concurrent assertion forms for the table's modules.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_TERM_TABLE_MACROS_SVH
`define SPARSE_POLYNOMIAL_TERM_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term table: package
// Sizes, item mode codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

	localparam int EXP_SLOTS = 64;
	localparam int IDX_W     = (EXP_SLOTS > 1) ? $clog2(EXP_SLOTS) : 1;
	localparam int EXP_W     = 6;
	localparam int COEF_W    = 32;
	localparam int MODE_W    = 2;
	// Compare width wide enough for both an exponent field and a slot index
	localparam int CMP_W     = ((IDX_W > EXP_W) ? IDX_W : EXP_W) + 1;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	typedef struct packed {
		logic             latch;
		logic             add_rd;
		logic             add_wr;
		logic             del;
		logic             scan_issue;
		logic [IDX_W-1:0] slot;
		logic             out_load;
	} spt_cmd_t;

	typedef struct packed {
		logic out_busy;
	} spt_sts_t;

endpackage

`default_nettype wire

// ===== design/spt_ifs.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term table: channel interfaces
// Valid/ready channels for incoming items and outgoing query results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spt_item_if;
	logic                               valid;
	logic                               ready;
	logic        [spt_pkg::MODE_W-1:0]  mode;
	logic signed [spt_pkg::COEF_W-1:0]  coefficient;
	logic        [spt_pkg::EXP_W-1:0]   exponent;
	logic        [spt_pkg::EXP_W-1:0]   range_end;
	logic signed [spt_pkg::COEF_W-1:0]  x_value;

	modport source (output valid, mode, coefficient, exponent, range_end, x_value,
		input ready);
	modport sink (input valid, mode, coefficient, exponent, range_end, x_value,
		output ready);
endinterface

interface spt_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [spt_pkg::COEF_W-1:0]  value_at_x;
	logic signed [spt_pkg::COEF_W-1:0]  coef_at_exp;
	logic        [spt_pkg::EXP_W-1:0]   degree;
	logic signed [spt_pkg::COEF_W-1:0]  smallest_coef;
	logic signed [spt_pkg::COEF_W-1:0]  largest_coef;
	logic                               is_empty;

	modport source (output valid, value_at_x, coef_at_exp, degree, smallest_coef,
		largest_coef, is_empty, input ready);
	modport sink (input valid, value_at_x, coef_at_exp, degree, smallest_coef,
		largest_coef, is_empty, output ready);
endinterface

`default_nettype wire

// ===== design/spt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term table: controller
// Sequences add, delete-range and query items and drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_polynomial_term_table_macros.svh"

module spt_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          item_valid,
	input  wire  [spt_pkg::MODE_W-1:0]   item_mode,
	output logic                         item_ready,
	output spt_pkg::spt_cmd_t            cmd,
	input  spt_pkg::spt_sts_t            sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD_RD = 3'd1;
	localparam logic [2:0] ST_ADD_WR = 3'd2;
	localparam logic [2:0] ST_DEL    = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_DRAIN  = 3'd5;
	localparam logic [2:0] ST_LOAD   = 3'd6;

	localparam logic [spt_pkg::IDX_W-1:0] LAST_SLOT = spt_pkg::IDX_W'(spt_pkg::EXP_SLOTS - 1);

	logic [2:0]                state_q, state_d;
	logic [spt_pkg::IDX_W-1:0] slot_q;
	logic                      drain_q;
	logic                      accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		cmd        = '0;
		cmd.slot   = slot_q;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					case (item_mode)
						spt_pkg::MODE_ADD:   state_d = ST_ADD_RD;
						spt_pkg::MODE_DEL:   state_d = ST_DEL;
						spt_pkg::MODE_QUERY: state_d = ST_SCAN;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: begin
				cmd.add_rd = 1'b1;
				state_d    = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_DEL: begin
				cmd.del = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (slot_q == LAST_SLOT) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// wait for the read and multiply stages to empty
				if (drain_q) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
			drain_q <= (state_q == ST_DRAIN) && !drain_q;
		end
	end

	`SPT_ASSERT_NEXT(a_query_starts_scan, clk, arst_n,
		accept && (item_mode == spt_pkg::MODE_QUERY), state_q == ST_SCAN,
		"query item did not start the slot scan")
	`SPT_ASSERT_NEXT(a_last_slot_drains, clk, arst_n,
		(state_q == ST_SCAN) && (slot_q == LAST_SLOT), (state_q == ST_DRAIN) && (slot_q == '0),
		"scan did not end after the last slot")

endmodule

`default_nettype wire

// ===== design/spt_dp.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term table: datapath
// Coefficient memory, presence bits, scan multiply-accumulate and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_polynomial_term_table_macros.svh"

module spt_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  spt_pkg::spt_cmd_t                  cmd,
	output spt_pkg::spt_sts_t                  sts,
	input  wire signed [spt_pkg::COEF_W-1:0]   coefficient,
	input  wire        [spt_pkg::EXP_W-1:0]    exponent,
	input  wire        [spt_pkg::EXP_W-1:0]    range_end,
	input  wire signed [spt_pkg::COEF_W-1:0]   x_value,
	spt_result_if.source                       result
);

	localparam int W  = spt_pkg::COEF_W;
	localparam int IW = spt_pkg::IDX_W;
	localparam int CW = spt_pkg::CMP_W;

	// latched item fields
	logic        [W-1:0]               coef_q;
	logic        [spt_pkg::EXP_W-1:0]  exp_q;
	logic        [spt_pkg::EXP_W-1:0]  end_q;
	logic        [W-1:0]               x_q;

	logic [spt_pkg::EXP_SLOTS-1:0] present_q;
	logic [W-1:0]                  coef_mem [spt_pkg::EXP_SLOTS];
	logic [W-1:0]                  rd_q;

	logic [CW-1:0] exp_cmp;
	logic          in_table;
	logic [IW-1:0] exp_idx;
	logic [IW-1:0] rd_addr;
	logic          rd_en;
	logic [W-1:0]  sum;
	logic          hit;
	logic          mem_we;
	logic [W-1:0]  wr_data;
	logic [spt_pkg::EXP_SLOTS-1:0] del_mask;

	// scan pipeline
	logic          v_s1, v_s2;
	logic [IW-1:0] idx_s1, idx_s2;
	logic          pres_s1, pres_s2;
	logic [W-1:0]  pw_q, pw_s1;
	logic [W-1:0]  prod_s2;
	logic signed [W-1:0] coef_s2;

	// accumulators
	logic [W-1:0]        acc_q, at_q;
	logic signed [W-1:0] lo_q, hi_q;
	logic [IW-1:0]       deg_q;
	logic                any_q;

	logic out_valid_q;

	assign exp_cmp  = CW'(exp_q);
	assign in_table = exp_cmp < CW'(spt_pkg::EXP_SLOTS);
	assign exp_idx  = exp_cmp[IW-1:0];
	assign rd_addr  = cmd.scan_issue ? cmd.slot : exp_idx;
	assign rd_en    = cmd.scan_issue || cmd.add_rd;

	assign sum     = rd_q + coef_q;
	assign hit     = in_table && present_q[exp_idx];
	// a present term whose sum reaches zero is dropped, not written
	assign mem_we  = cmd.add_wr && in_table && (!hit || (sum != '0));
	assign wr_data = hit ? sum : coef_q;

	always_comb begin
		for (int i = 0; i < spt_pkg::EXP_SLOTS; i++) begin
			del_mask[i] = (CW'(i) >= CW'(exp_q)) && (CW'(i) <= CW'(end_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			coef_q <= coefficient;
			exp_q  <= exponent;
			end_q  <= range_end;
			x_q    <= x_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= coef_mem[rd_addr];
		if (mem_we) coef_mem[exp_idx] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.add_wr && in_table) begin
			if (!hit) present_q[exp_idx] <= 1'b1;
			else if (sum == '0) present_q[exp_idx] <= 1'b0;
		end else if (cmd.del) begin
			present_q <= present_q & ~del_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pw_q <= W'(1);
		end else if (cmd.scan_issue) begin
			pw_q <= pw_q * x_q;
		end
		pw_s1   <= pw_q;
		idx_s1  <= cmd.slot;
		pres_s1 <= present_q[cmd.slot];
		prod_s2 <= rd_q * pw_s1;
		coef_s2 <= rd_q;
		idx_s2  <= idx_s1;
		pres_s2 <= pres_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			acc_q <= '0;
			at_q  <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
			deg_q <= '0;
			any_q <= 1'b0;
		end else if (v_s2 && pres_s2) begin
			acc_q <= acc_q + prod_s2;
			if (!any_q || (coef_s2 < lo_q)) lo_q <= coef_s2;
			if (!any_q || (coef_s2 > hi_q)) hi_q <= coef_s2;
			deg_q <= idx_s2;
			any_q <= 1'b1;
			if (in_table && (idx_s2 == exp_idx)) at_q <= coef_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.value_at_x    <= acc_q;
			result.coef_at_exp   <= at_q;
			result.degree        <= spt_pkg::EXP_W'(deg_q);
			result.smallest_coef <= lo_q;
			result.largest_coef  <= hi_q;
			result.is_empty      <= !any_q;
		end
	end

	assign result.valid = out_valid_q;
	assign sts.out_busy = out_valid_q && !result.ready;

	`SPT_ASSERT_IMPL(a_no_result_overwrite, clk, arst_n,
		cmd.out_load, !(out_valid_q && !result.ready),
		"result register loaded while the previous result is still held")
	`SPT_ASSERT_IMPL(a_update_outside_scan, clk, arst_n,
		cmd.add_wr || cmd.del || cmd.latch, !v_s1 && !v_s2,
		"table update while the scan pipeline is busy")

endmodule

`default_nettype wire

// ===== design/sparse_polynomial_term_table.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial term table: top level
// Polynomial kept as a table of terms indexed by exponent; add, delete, query.
// ----------------------------------------------------------------------------
// Usage:
//   term   - item channel (valid/ready). mode selects add-term, delete-range
//            or query; mode 3 is taken and ignored.
//   result - one item per query, none for other modes.
// Sequencing (one item in flight):
//   add-term steps: accept, memory read, write back.
//   delete-range: accept, then all presence bits of the range clear at once.
//   query: from accept to result valid, one coefficient memory read per
//   slot, then a registered multiply by the running power of x and an
//   accumulate, a drain of the read and multiply stages, and a load of the
//   result register; the next item is taken once that load is done.
//   The single-port read of the coefficient memory sets the scan length.
// Reset clears every presence bit, so the table starts empty; the
// coefficient memory holds no reset value and is only read behind those bits.
// A held result sits in the output register while the next item is taken;
// a later query waits in its last step until that result is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_term_table (
	input  wire           clk,
	input  wire           arst_n,
	spt_item_if.sink      term,
	spt_result_if.source  result
);

	spt_pkg::spt_cmd_t cmd;
	spt_pkg::spt_sts_t sts;
	logic              term_ready;

	assign term.ready = term_ready;

	spt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (term.valid),
		.item_mode  (term.mode),
		.item_ready (term_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	spt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.coefficient (term.coefficient),
		.exponent    (term.exponent),
		.range_end   (term.range_end),
		.x_value     (term.x_value),
		.result      (result)
	);

endmodule

`default_nettype wire
